>>> rtl/brm_pkg.sv
// Types and constants shared by the bipartite reach matching block.
// No dependencies.
package brm_pkg;

  localparam int unsigned CoordW = 16;
  localparam logic [7:0] ReachScale = 8'd200;

  localparam logic [1:0] CMD_LOAD_PASSENGER = 2'd0;
  localparam logic [1:0] CMD_LOAD_SERVER = 2'd1;
  localparam logic [1:0] CMD_SOLVE = 2'd2;

  localparam logic REG_SPEED = 1'b0;
  localparam logic REG_TIME_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic signed [15:0] coord_x;
    logic signed [15:0] coord_y;
  } in_beat_t;

  typedef struct packed {
    logic [6:0] matched_count;
    logic overflow;
  } out_beat_t;

endpackage

>>> rtl/bipartite_reach_matching_unit.sv
// Top level of the bipartite reach matching block: point stores, reach test
// and augmenting-path sequencer. Depends on brm_pkg and brm_ram.
//
//  channel | signals                                   | handshake
//  in      | start_i, busy_o, in_i (brm_pkg::in_beat_t)  | start_i & !busy_o
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | valid & ready
//  out     | done_o, out_o (brm_pkg::out_beat_t)        | strobe, one cycle
//
// Loads are accepted while idle. A solve walks the graph: each reach test steps
// through index check, RAM read, distance, multiply and compare; a reachable
// passenger that is already matched adds the partner read (ST_PRD, ST_PART),
// and each pop or augment step above the root frame goes on through ST_CLRP.
// done_o rises in ST_DONE, the last state of a solve. Reset clears counts and
// flags; no clearing pass. The receiver cannot stall done_o.
module bipartite_reach_matching_unit #(
  parameter int unsigned MaxServers = 64,
  parameter int unsigned MaxPassengers = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  brm_pkg::in_beat_t   in_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic                cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  output logic                done_o,
  output brm_pkg::out_beat_t  out_o
);

  localparam int unsigned SW = (MaxServers > 1) ? $clog2(MaxServers) : 1;
  localparam int unsigned PW = (MaxPassengers > 1) ? $clog2(MaxPassengers) : 1;
  localparam int unsigned SCW = $clog2(MaxServers + 1);
  localparam int unsigned PCW = $clog2(MaxPassengers + 1);
  localparam int unsigned FW = SW + PCW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CLRP = 4'd1;
  localparam logic [3:0] ST_ROOT = 4'd2;
  localparam logic [3:0] ST_TEST = 4'd3;
  localparam logic [3:0] ST_RD = 4'd4;
  localparam logic [3:0] ST_DIST = 4'd5;
  localparam logic [3:0] ST_MUL = 4'd6;
  localparam logic [3:0] ST_CMP = 4'd7;
  localparam logic [3:0] ST_PART = 4'd8;
  localparam logic [3:0] ST_AUG = 4'd9;
  localparam logic [3:0] ST_POP = 4'd10;
  localparam logic [3:0] ST_DONE = 4'd11;
  localparam logic [3:0] ST_PRD = 4'd12;

  logic [3:0] state_q, state_d;
  logic [15:0] speed_q, time_q;
  logic [SCW-1:0] scnt_q, scnt_d;
  logic [PCW-1:0] pcnt_q, pcnt_d;
  logic drop_q, drop_d;
  logic [6:0] total_q, total_d;
  logic [SCW-1:0] root_q, root_d;
  logic [SCW-1:0] depth_q, depth_d;
  logic [SW-1:0] cur_s_q, cur_s_d;
  logic [PCW-1:0] cur_j_q, cur_j_d;
  logic [MaxServers-1:0] visited_q, visited_d;
  logic [MaxPassengers-1:0] pvalid_q, pvalid_d;
  logic [16:0] dx_q, dy_q;
  logic [17:0] dist_q;
  logic [25:0] scaled_q;
  logic [31:0] limit_q;
  logic aug_mode_q;

  // point stores
  logic p_we, s_we;
  logic [PW-1:0] p_raddr;
  logic [SW-1:0] s_raddr;
  logic [31:0] p_rdata, s_rdata;

  assign p_we = (state_q == ST_IDLE) && start_i &&
                (in_i.command == brm_pkg::CMD_LOAD_PASSENGER) &&
                (pcnt_q < PCW'(MaxPassengers));
  assign s_we = (state_q == ST_IDLE) && start_i &&
                (in_i.command == brm_pkg::CMD_LOAD_SERVER) &&
                (scnt_q < SCW'(MaxServers));
  assign p_raddr = cur_j_q[PW-1:0];
  assign s_raddr = cur_s_q;

  brm_ram #(.Width(32), .Depth(MaxPassengers)) u_pass (
    .clk_i, .we_i(p_we), .waddr_i(pcnt_q[PW-1:0]),
    .wdata_i({in_i.coord_x, in_i.coord_y}), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );
  brm_ram #(.Width(32), .Depth(MaxServers)) u_serv (
    .clk_i, .we_i(s_we), .waddr_i(scnt_q[SW-1:0]),
    .wdata_i({in_i.coord_x, in_i.coord_y}), .raddr_i(s_raddr), .rdata_o(s_rdata)
  );

  // partner store and search stack
  logic part_we;
  logic [PW-1:0] part_waddr, part_raddr;
  logic [SW-1:0] part_wdata, part_rdata;
  logic stk_we;
  logic [SW-1:0] stk_waddr, stk_raddr;
  logic [FW-1:0] stk_wdata, stk_rdata;

  brm_ram #(.Width(SW), .Depth(MaxPassengers)) u_part (
    .clk_i, .we_i(part_we), .waddr_i(part_waddr), .wdata_i(part_wdata),
    .raddr_i(part_raddr), .rdata_o(part_rdata)
  );
  brm_ram #(.Width(FW), .Depth(MaxServers)) u_stk (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  logic signed [16:0] sx, sy, px, py, ddx, ddy;
  assign sx = {s_rdata[31], s_rdata[31:16]};
  assign sy = {s_rdata[15], s_rdata[15:0]};
  assign px = {p_rdata[31], p_rdata[31:16]};
  assign py = {p_rdata[15], p_rdata[15:0]};
  assign ddx = sx - px;
  assign ddy = sy - py;

  logic [SW-1:0] top_idx;
  assign top_idx = SW'(depth_q - SCW'(1));

  assign busy_o = (state_q != ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    scnt_d = scnt_q;
    pcnt_d = pcnt_q;
    drop_d = drop_q;
    total_d = total_q;
    root_d = root_q;
    depth_d = depth_q;
    cur_s_d = cur_s_q;
    cur_j_d = cur_j_q;
    visited_d = visited_q;
    pvalid_d = pvalid_q;
    part_we = 1'b0;
    part_waddr = cur_j_q[PW-1:0];
    part_wdata = cur_s_q;
    part_raddr = cur_j_q[PW-1:0];
    stk_we = 1'b0;
    stk_waddr = top_idx;
    stk_wdata = {cur_s_q, cur_j_q};
    stk_raddr = top_idx;
    done_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (in_i.command)
            brm_pkg::CMD_LOAD_PASSENGER: begin
              if (p_we) pcnt_d = pcnt_q + PCW'(1);
              else drop_d = 1'b1;
            end
            brm_pkg::CMD_LOAD_SERVER: begin
              if (s_we) scnt_d = scnt_q + SCW'(1);
              else drop_d = 1'b1;
            end
            brm_pkg::CMD_SOLVE: begin
              pvalid_d = '0;
              total_d = '0;
              root_d = '0;
              state_d = ST_ROOT;
            end
            default: ;
          endcase
        end
      end
      ST_CLRP: begin
        // frame read back: restore it, then continue augment or advance
        cur_s_d = stk_rdata[FW-1:PCW];
        if (aug_mode_q) begin
          cur_j_d = stk_rdata[PCW-1:0];
          state_d = ST_AUG;
        end else begin
          cur_j_d = stk_rdata[PCW-1:0] + PCW'(1);
          state_d = ST_TEST;
        end
      end
      ST_ROOT: begin
        if (root_q >= scnt_q) begin
          state_d = ST_DONE;
        end else begin
          visited_d = '0;
          visited_d[root_q[SW-1:0]] = 1'b1;
          cur_s_d = root_q[SW-1:0];
          cur_j_d = '0;
          depth_d = SCW'(1);
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (cur_j_q >= pcnt_q) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_RD;
        end
      end
      ST_RD: state_d = ST_DIST;
      ST_DIST: state_d = ST_MUL;
      ST_MUL: state_d = ST_CMP;
      ST_CMP: begin
        if ({6'd0, scaled_q} <= limit_q) begin
          stk_we = 1'b1;
          if (!pvalid_q[cur_j_q[PW-1:0]]) begin
            total_d = total_q + 7'd1;
            state_d = ST_AUG;
          end else begin
            state_d = ST_PRD;
          end
        end else begin
          cur_j_d = cur_j_q + PCW'(1);
          state_d = ST_TEST;
        end
      end
      ST_PRD: state_d = ST_PART;
      ST_PART: begin
        if (visited_q[part_rdata] || depth_q >= SCW'(MaxServers)) begin
          cur_j_d = cur_j_q + PCW'(1);
        end else begin
          visited_d[part_rdata] = 1'b1;
          cur_s_d = part_rdata;
          cur_j_d = '0;
          depth_d = depth_q + SCW'(1);
        end
        state_d = ST_TEST;
      end
      ST_AUG: begin
        // rewrite partners from the top frame down; lower frames come back
        // through ST_CLRP from the stack
        part_we = 1'b1;
        pvalid_d[cur_j_q[PW-1:0]] = 1'b1;
        if (depth_q == SCW'(1)) begin
          root_d = root_q + SCW'(1);
          state_d = ST_ROOT;
        end else begin
          depth_d = depth_q - SCW'(1);
          stk_raddr = SW'(depth_q - SCW'(2));
          state_d = ST_CLRP;
        end
      end
      ST_POP: begin
        if (depth_q == SCW'(1)) begin
          root_d = root_q + SCW'(1);
          state_d = ST_ROOT;
        end else begin
          depth_d = depth_q - SCW'(1);
          stk_raddr = SW'(depth_q - SCW'(2));
          state_d = ST_CLRP;
        end
      end
      ST_DONE: begin
        done_o = 1'b1;
        scnt_d = '0;
        pcnt_d = '0;
        drop_d = 1'b0;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      speed_q <= '0;
      time_q <= '0;
      scnt_q <= '0;
      pcnt_q <= '0;
      drop_q <= 1'b0;
      total_q <= '0;
      root_q <= '0;
      depth_q <= '0;
      cur_s_q <= '0;
      cur_j_q <= '0;
      visited_q <= '0;
      pvalid_q <= '0;
      aug_mode_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == brm_pkg::REG_SPEED) speed_q <= cfg_data_i;
        else time_q <= cfg_data_i;
      end
      state_q <= state_d;
      scnt_q <= scnt_d;
      pcnt_q <= pcnt_d;
      drop_q <= drop_d;
      total_q <= total_d;
      root_q <= root_d;
      depth_q <= depth_d;
      cur_s_q <= cur_s_d;
      cur_j_q <= cur_j_d;
      visited_q <= visited_d;
      pvalid_q <= pvalid_d;
      if (state_q == ST_AUG) aug_mode_q <= 1'b1;
      else if (state_q == ST_POP) aug_mode_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    dx_q <= ddx[16] ? 17'(-ddx) : 17'(ddx);
    dy_q <= ddy[16] ? 17'(-ddy) : 17'(ddy);
    dist_q <= 18'(dx_q) + 18'(dy_q);
    scaled_q <= 26'(dist_q) * 26'(brm_pkg::ReachScale);
    limit_q <= speed_q * time_q;
    out_o.matched_count <= total_q;
    out_o.overflow <= drop_q;
  end

  // out_o registers are loaded each cycle; ST_DONE shows last cycle's totals
  // because total and drop settle before entering ST_DONE.

endmodule

>>> rtl/brm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module brm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Testbench for bipartite_reach_matching_unit: point loads, solves and register writes,
// checked against an in-bench matching predictor. Depends on brm_pkg and the RTL.
module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  brm_pkg::in_beat_t in_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic done_o;
  brm_pkg::out_beat_t out_o;

  bipartite_reach_matching_unit uut (.*);

  always #5 clk_i = ~clk_i;

  brm_pkg::in_beat_t pending_q[$];
  brm_pkg::out_beat_t match_q[$];
  int unsigned fail_cnt = 0;
  int gap = 0;
  bit idle_on = 1'b1;
  bit hold_off = 1'b0;

  logic [15:0] m_speed = '0, m_tlim = '0;
  int pas_x[64], pas_y[64], srv_x[64], srv_y[64];
  int pas_cnt = 0, srv_cnt = 0;
  bit dropped = 1'b0;

  task automatic queue_item(brm_pkg::in_beat_t b);
    pending_q = {pending_q, b};
  endtask

  function automatic bit reaches(int s, int p);
    longint dx, dy;
    dx = srv_x[s] - pas_x[p];
    dy = srv_y[s] - pas_y[p];
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx + dy) * 200 <= longint'(m_speed) * longint'(m_tlim);
  endfunction

  function automatic int max_matching();
    int total, r, depth, j, m, k;
    bit found;
    bit pv[64];
    bit vis[64];
    int partner[64], st_s[64], st_n[64];
    total = 0;
    for (k = 0; k < 64; k++) pv[k] = 1'b0;
    for (r = 0; r < srv_cnt; r++) begin
      for (k = 0; k < 64; k++) vis[k] = 1'b0;
      depth = 1; st_s[0] = r; st_n[0] = 0; vis[r] = 1'b1; found = 1'b0;
      while (depth > 0 && !found) begin
        j = st_n[depth-1];
        while (j < pas_cnt && !reaches(st_s[depth-1], j)) j++;
        if (j >= pas_cnt) begin
          depth--;
          if (depth > 0) st_n[depth-1]++;
        end else begin
          st_n[depth-1] = j;
          if (!pv[j]) begin
            for (k = depth; k > 0; k--) begin
              partner[st_n[k-1]] = st_s[k-1];
              pv[st_n[k-1]] = 1'b1;
            end
            found = 1'b1;
          end else begin
            m = partner[j];
            if (vis[m] || depth >= 64) st_n[depth-1] = j + 1;
            else begin
              vis[m] = 1'b1; st_s[depth] = m; st_n[depth] = 0; depth++;
            end
          end
        end
      end
      total += found;
    end
    return total;
  endfunction

  task automatic predict_beat(brm_pkg::in_beat_t b);
    brm_pkg::out_beat_t r;
    case (b.command)
      brm_pkg::CMD_LOAD_PASSENGER: begin
        if (pas_cnt < 64) begin
          pas_x[pas_cnt] = b.coord_x; pas_y[pas_cnt] = b.coord_y; pas_cnt++;
        end else dropped = 1'b1;
      end
      brm_pkg::CMD_LOAD_SERVER: begin
        if (srv_cnt < 64) begin
          srv_x[srv_cnt] = b.coord_x; srv_y[srv_cnt] = b.coord_y; srv_cnt++;
        end else dropped = 1'b1;
      end
      brm_pkg::CMD_SOLVE: begin
        r.matched_count = 7'(max_matching());
        r.overflow = dropped;
        match_q = {match_q, r};
        pas_cnt = 0; srv_cnt = 0; dropped = 1'b0;
      end
      default: ;
    endcase
  endtask

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        predict_beat(in_i);
        void'(pending_q.pop_front());
      end
      if (start_i && busy_o) begin
      end else if (gap > 0) begin
        gap <= gap - 1;
        start_i <= 1'b0;
      end else if (pending_q.size() > 0 && !hold_off) begin
        if (idle_on && $urandom_range(0, 11) == 0) begin
          gap <= $urandom_range(1, 19) - 1;
          start_i <= 1'b0;
        end else begin
          start_i <= 1'b1;
          in_i <= pending_q[0];
        end
      end else start_i <= 1'b0;
    end
  end

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    fail_cnt++;
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (match_q.size() == 0) report_mismatch("unexpected beat", 1, 0);
      else begin
        if (out_o.matched_count !== match_q[0].matched_count)
          report_mismatch("matched_count", out_o.matched_count, match_q[0].matched_count);
        if (out_o.overflow !== match_q[0].overflow)
          report_mismatch("overflow", out_o.overflow, match_q[0].overflow);
        void'(match_q.pop_front());
      end
    end
  end

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == brm_pkg::REG_SPEED) m_speed = val;
    else m_tlim = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i);
    while (pending_q.size() != 0 || match_q.size() != 0 || start_i || busy_o);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic brm_pkg::in_beat_t mk(logic [1:0] c, int x, int y);
    brm_pkg::in_beat_t b;
    if (x > 32767) x = 32767;
    if (x < -32768) x = -32768;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    b.command = c; b.coord_x = 16'(x); b.coord_y = 16'(y);
    return b;
  endfunction

  // one case: interleaved loads, mostly near a center, with stray unused commands, then a solve
  task automatic add_case(int np, int ns, int spread);
    int cx, cy, x, y;
    logic [1:0] c;
    cx = int'($urandom_range(0, 65535)) - 32768;
    cy = int'($urandom_range(0, 65535)) - 32768;
    while (np + ns > 0) begin
      if (np > 0 && (ns == 0 || $urandom_range(0, 1))) begin
        c = brm_pkg::CMD_LOAD_PASSENGER; np--;
      end else begin
        c = brm_pkg::CMD_LOAD_SERVER; ns--;
      end
      if ($urandom_range(0, 15) == 0) begin
        x = int'($urandom_range(0, 65535)) - 32768;
        y = int'($urandom_range(0, 65535)) - 32768;
      end else begin
        x = cx + int'($urandom_range(0, 2 * spread)) - spread;
        y = cy + int'($urandom_range(0, 2 * spread)) - spread;
      end
      queue_item(mk(c, x, y));
      if ($urandom_range(0, 40) == 0)
        queue_item(mk(CMD_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535)));
    end
    queue_item(mk(brm_pkg::CMD_SOLVE, $urandom_range(0, 65535), $urandom_range(0, 65535)));
  endtask

  task automatic run_phase(logic [15:0] spd, logic [15:0] tl, int n_items, bit idle);
    int reach, spread;
    write_reg(brm_pkg::REG_SPEED, spd);
    write_reg(brm_pkg::REG_TIME_LIMIT, tl);
    idle_on = idle;
    reach = (int'(spd) * int'(tl)) / 200;
    if (reach < 0 || reach > 20000) reach = 20000;
    spread = reach + 2;
    while (n_items > 0) begin
      add_case($urandom_range(0, 6), $urandom_range(0, 6), spread);
      n_items -= 8;
    end
    drain();
  endtask

  initial begin
    int i;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_reg(brm_pkg::REG_SPEED, 16'hFFFF);
    write_reg(brm_pkg::REG_TIME_LIMIT, 16'hFFFF);
    // extremes, empty solves, unused command
    queue_item(mk(brm_pkg::CMD_SOLVE, 0, 0));
    queue_item(mk(brm_pkg::CMD_LOAD_PASSENGER, -32768, -32768));
    queue_item(mk(brm_pkg::CMD_LOAD_SERVER, 32767, 32767));
    queue_item(mk(CMD_UNUSED, -1, -1));
    queue_item(mk(brm_pkg::CMD_SOLVE, -1, -1));
    queue_item(mk(brm_pkg::CMD_LOAD_PASSENGER, 5, 5));
    queue_item(mk(brm_pkg::CMD_SOLVE, 32767, -32768));
    queue_item(mk(brm_pkg::CMD_LOAD_SERVER, 0, 0));
    queue_item(mk(brm_pkg::CMD_SOLVE, 0, 0));
    drain();
    write_reg(brm_pkg::REG_SPEED, 16'd0);
    queue_item(mk(brm_pkg::CMD_LOAD_PASSENGER, 7, -7));
    queue_item(mk(brm_pkg::CMD_LOAD_SERVER, 7, -7));
    queue_item(mk(brm_pkg::CMD_LOAD_SERVER, 7, -6));
    queue_item(mk(brm_pkg::CMD_LOAD_PASSENGER, 7, -6));
    queue_item(mk(brm_pkg::CMD_SOLVE, 0, 0));
    drain();
    // full stores with overflow, no edges
    for (i = 0; i < 66; i++) begin
      queue_item(mk(brm_pkg::CMD_LOAD_PASSENGER, i * 3, 0));
      queue_item(mk(brm_pkg::CMD_LOAD_SERVER, i * 3 + 1, 0));
    end
    queue_item(mk(brm_pkg::CMD_SOLVE, 0, 0));
    drain();
    // full stores, complete graph
    write_reg(brm_pkg::REG_SPEED, 16'hFFFF);
    for (i = 0; i < 64; i++) begin
      queue_item(mk(brm_pkg::CMD_LOAD_SERVER, i, -i));
      queue_item(mk(brm_pkg::CMD_LOAD_PASSENGER, -i, i));
    end
    queue_item(mk(brm_pkg::CMD_LOAD_SERVER, 1, 1));
    queue_item(mk(brm_pkg::CMD_SOLVE, 0, 0));
    drain();
    run_phase(16'd0, 16'd0, 200, 1'b1);
    run_phase(16'd200, 16'd10, 250, 1'b1);
    run_phase(16'd1000, 16'd1000, 250, 1'b1);
    run_phase(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 255)), 250, 1'b1);
    hold_off = 1'b1;
    repeat ($urandom_range(1, 30)) @(posedge clk_i);
    hold_off = 1'b0;
    run_phase(16'hFFFF, 16'd1, 250, 1'b0);
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end
endmodule
